/* sv/mbps_pkg.sv */
`timescale 1ns / 1ps

package mbps_pkg;

    localparam int DEFAULT_MAX_PATTERN = 16;
    localparam int DEFAULT_INDEX_WIDTH = 32;

    // Bytes that the pattern registers can hold; positions beyond are wildcards.
    localparam int PATTERN_BYTES = 16;

    localparam int CFG_DATA_WIDTH = 64;
    localparam int CFG_ADDR_WIDTH = 3;
    localparam int PLEN_WIDTH     = 5;
    localparam int OFFSET_WIDTH   = 32;
    localparam int LOC_WIDTH      = 34;

    localparam logic [CFG_ADDR_WIDTH-1:0] REG_PATTERN_LOW  = 3'd0;
    localparam logic [CFG_ADDR_WIDTH-1:0] REG_PATTERN_HIGH = 3'd1;
    localparam logic [CFG_ADDR_WIDTH-1:0] REG_CARE_MASK    = 3'd2;
    localparam logic [CFG_ADDR_WIDTH-1:0] REG_PATTERN_LEN  = 3'd3;
    localparam logic [CFG_ADDR_WIDTH-1:0] REG_RESULT_OFF   = 3'd4;

    typedef struct packed {
        logic [PATTERN_BYTES*8-1:0] pattern;
        logic [PATTERN_BYTES-1:0]   care;
        logic [PLEN_WIDTH-1:0]      plen;
        logic [OFFSET_WIDTH-1:0]    offset;
    } cfg_t;

endpackage

/* sv/mbps_cfg_regs.sv */
`timescale 1ns / 1ps

module mbps_cfg_regs import mbps_pkg::*; #(
    parameter int MAX_PATTERN = DEFAULT_MAX_PATTERN,
    parameter int LEN_WIDTH   = $clog2(MAX_PATTERN + 1)
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_we,
    input  logic [CFG_ADDR_WIDTH-1:0] cfg_addr,
    input  logic [CFG_DATA_WIDTH-1:0] cfg_wdata,
    output cfg_t                      cfg,
    output logic [LEN_WIDTH-1:0]      active_len
);

    localparam int CW = (LEN_WIDTH > PLEN_WIDTH) ? LEN_WIDTH : PLEN_WIDTH;

    logic [63:0]             pat_low_reg;
    logic [63:0]             pat_high_reg;
    logic [15:0]             care_reg;
    logic [PLEN_WIDTH-1:0]   plen_reg;
    logic [OFFSET_WIDTH-1:0] offset_reg;
    logic [CW-1:0]           plen_ext;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pat_low_reg  <= '0;
            pat_high_reg <= '0;
            care_reg     <= '0;
            plen_reg     <= PLEN_WIDTH'(1);
            offset_reg   <= '0;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_PATTERN_LOW:  pat_low_reg  <= cfg_wdata;
                REG_PATTERN_HIGH: pat_high_reg <= cfg_wdata;
                REG_CARE_MASK:    care_reg     <= cfg_wdata[15:0];
                REG_PATTERN_LEN:  plen_reg     <= cfg_wdata[PLEN_WIDTH-1:0];
                REG_RESULT_OFF:   offset_reg   <= cfg_wdata[OFFSET_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    assign cfg.pattern = {pat_high_reg, pat_low_reg};
    assign cfg.care    = care_reg;
    assign cfg.plen    = plen_reg;
    assign cfg.offset  = offset_reg;

    // A length of zero acts as one; anything above the window depth saturates.
    always_comb begin
        plen_ext = CW'(plen_reg);
        if (plen_reg == '0) begin
            active_len = LEN_WIDTH'(1);
        end else if (plen_ext > CW'(MAX_PATTERN)) begin
            active_len = LEN_WIDTH'(MAX_PATTERN);
        end else begin
            active_len = plen_ext[LEN_WIDTH-1:0];
        end
    end

endmodule

/* sv/mbps_window.sv */
`timescale 1ns / 1ps

module mbps_window import mbps_pkg::*; #(
    parameter int MAX_PATTERN = DEFAULT_MAX_PATTERN,
    parameter int INDEX_WIDTH = DEFAULT_INDEX_WIDTH,
    parameter int LEN_WIDTH   = $clog2(MAX_PATTERN + 1)
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [7:0]               s_data_byte,
    input  logic                     s_last_byte,
    input  logic                     advance,
    output logic                     stg_valid,
    output logic                     stg_last,
    output logic [LEN_WIDTH-1:0]     stg_fill,
    output logic [INDEX_WIDTH-1:0]   stg_index,
    output logic [MAX_PATTERN*8-1:0] window
);

    logic [7:0]             window_reg [MAX_PATTERN];
    logic [LEN_WIDTH-1:0]   fill_reg;
    logic [LEN_WIDTH-1:0]   fill_next;
    logic [INDEX_WIDTH-1:0] index_reg;
    logic                   stg_valid_reg;
    logic                   stg_last_reg;
    logic [LEN_WIDTH-1:0]   stg_fill_reg;
    logic [INDEX_WIDTH-1:0] stg_index_reg;
    logic                   accept;

    assign s_ready = !stg_valid_reg || advance;
    assign accept  = s_valid && s_ready;

    assign fill_next = (fill_reg < LEN_WIDTH'(MAX_PATTERN)) ? fill_reg + LEN_WIDTH'(1)
                                                             : fill_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stg_valid_reg <= 1'b0;
            fill_reg      <= '0;
            index_reg     <= '0;
        end else begin
            if (s_ready) begin
                stg_valid_reg <= s_valid;
            end
            if (accept) begin
                fill_reg  <= s_last_byte ? '0 : fill_next;
                index_reg <= s_last_byte ? '0 : index_reg + INDEX_WIDTH'(1);
            end
        end
    end

    // The window holds the newest byte at entry zero; it survives the end of a scan.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < MAX_PATTERN; i++) begin
                window_reg[i] <= '0;
            end
        end else if (accept) begin
            window_reg[0] <= s_data_byte;
            for (int i = 1; i < MAX_PATTERN; i++) begin
                window_reg[i] <= window_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            stg_last_reg  <= s_last_byte;
            stg_fill_reg  <= fill_next;
            stg_index_reg <= index_reg;
        end
    end

    assign stg_valid = stg_valid_reg;
    assign stg_last  = stg_last_reg;
    assign stg_fill  = stg_fill_reg;
    assign stg_index = stg_index_reg;

    always_comb begin
        for (int i = 0; i < MAX_PATTERN; i++) begin
            window[i*8 +: 8] = window_reg[i];
        end
    end

endmodule

/* sv/mbps_match.sv */
`timescale 1ns / 1ps

module mbps_match import mbps_pkg::*; #(
    parameter int MAX_PATTERN = DEFAULT_MAX_PATTERN,
    parameter int LEN_WIDTH   = $clog2(MAX_PATTERN + 1)
) (
    input  cfg_t                     cfg,
    input  logic [LEN_WIDTH-1:0]     active_len,
    input  logic [MAX_PATTERN*8-1:0] window,
    output logic                     matched
);

    // Only the first sixteen pattern positions can ever be compared.
    localparam int CMP = (MAX_PATTERN < PATTERN_BYTES) ? MAX_PATTERN : PATTERN_BYTES;
    localparam int IXW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

    logic [7:0]     win [MAX_PATTERN];
    logic [CMP-1:0] miss;

    always_comb begin
        for (int i = 0; i < MAX_PATTERN; i++) begin
            win[i] = window[i*8 +: 8];
        end
    end

    // Pattern byte i lines up with window entry len-1-i (oldest byte first).
    for (genvar i = 0; i < CMP; i++) begin : g_pos
        logic [LEN_WIDTH-1:0] pos;
        assign pos = active_len - LEN_WIDTH'(1) - LEN_WIDTH'(i);
        assign miss[i] = (LEN_WIDTH'(i) < active_len) && cfg.care[i]
                         && (win[pos[IXW-1:0]] != cfg.pattern[i*8 +: 8]);
    end

    assign matched = (miss == '0);

endmodule

/* sv/masked_byte_pattern_scanner_top.sv */
`timescale 1ns / 1ps

// Masked byte pattern scanner.
// Bytes enter on the s_ channel, one per item, with s_last_byte on the final
// byte of a scan. Each byte is shifted into a window of the most recent bytes,
// and the newest pattern_length bytes are compared with the pattern, skipping
// positions whose care bit is clear. The first match of a scan yields one item
// on the m_ channel with m_found high and m_location equal to the match start
// index plus result_offset; later matches in that scan give nothing. A scan
// that ends without a match yields one item with m_found low on its last byte.
// m_valid is registered behind the window stage: one register holds
// the window, the compare logic sits between it and the output register. The block
// takes one byte per cycle whenever the output register is empty or being read.
// While m_valid waits for m_ready the output holds; s_ready falls once the window
// stage is also full. Reset empties both stages, clears the window, the fill count,
// the byte index and the match flag, and returns the registers to their reset
// values. The user must make configuration writes while no scan is active.
module masked_byte_pattern_scanner_top import mbps_pkg::*; #(
    parameter int MAX_PATTERN = DEFAULT_MAX_PATTERN,
    parameter int INDEX_WIDTH = DEFAULT_INDEX_WIDTH
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_we,
    input  logic [CFG_ADDR_WIDTH-1:0]   cfg_addr,
    input  logic [CFG_DATA_WIDTH-1:0]   cfg_wdata,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [7:0]                  s_data_byte,
    input  logic                        s_last_byte,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic                        m_found,
    output logic signed [LOC_WIDTH-1:0] m_location
);

    localparam int LEN_WIDTH = $clog2(MAX_PATTERN + 1);

    cfg_t                     cfg;
    logic [LEN_WIDTH-1:0]     active_len;
    logic                     advance;
    logic                     stg_valid;
    logic                     stg_last;
    logic [LEN_WIDTH-1:0]     stg_fill;
    logic [INDEX_WIDTH-1:0]   stg_index;
    logic [MAX_PATTERN*8-1:0] window;
    logic                     matched;
    logic                     hit;
    logic                     miss_end;
    logic [INDEX_WIDTH-1:0]   start;
    logic [LOC_WIDTH-1:0]     start_loc;
    logic [LOC_WIDTH-1:0]     location;

    logic                     match_done_reg;
    logic                     m_valid_reg;
    logic                     m_found_reg;
    logic [LOC_WIDTH-1:0]     m_location_reg;

    mbps_cfg_regs #(
        .MAX_PATTERN (MAX_PATTERN),
        .LEN_WIDTH   (LEN_WIDTH)
    ) u_cfg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .cfg        (cfg),
        .active_len (active_len)
    );

    mbps_window #(
        .MAX_PATTERN (MAX_PATTERN),
        .INDEX_WIDTH (INDEX_WIDTH),
        .LEN_WIDTH   (LEN_WIDTH)
    ) u_window (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data_byte (s_data_byte),
        .s_last_byte (s_last_byte),
        .advance     (advance),
        .stg_valid   (stg_valid),
        .stg_last    (stg_last),
        .stg_fill    (stg_fill),
        .stg_index   (stg_index),
        .window      (window)
    );

    mbps_match #(
        .MAX_PATTERN (MAX_PATTERN),
        .LEN_WIDTH   (LEN_WIDTH)
    ) u_match (
        .cfg        (cfg),
        .active_len (active_len),
        .window     (window),
        .matched    (matched)
    );

    assign advance  = !m_valid_reg || m_ready;
    assign hit      = !match_done_reg && (stg_fill >= active_len) && matched;
    assign miss_end = !match_done_reg && stg_last && !hit;

    // The start index wraps with the byte index.
    assign start = stg_index + INDEX_WIDTH'(1) - INDEX_WIDTH'(active_len);

    if (INDEX_WIDTH >= LOC_WIDTH) begin : g_start_trunc
        assign start_loc = start[LOC_WIDTH-1:0];
    end else begin : g_start_ext
        assign start_loc = {{(LOC_WIDTH-INDEX_WIDTH){1'b0}}, start};
    end

    assign location = start_loc
                    + {{(LOC_WIDTH-OFFSET_WIDTH){cfg.offset[OFFSET_WIDTH-1]}}, cfg.offset};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            match_done_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= stg_valid && (hit || miss_end);
            if (stg_valid) begin
                match_done_reg <= stg_last ? 1'b0 : (match_done_reg || hit);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && stg_valid) begin
            m_found_reg    <= hit;
            m_location_reg <= hit ? location : '0;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_found    = m_found_reg;
    assign m_location = m_location_reg;

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps

module tb;
    import mbps_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int WIN_DEPTH    = DEFAULT_MAX_PATTERN;
    localparam int SETTLE       = 4;
    localparam int LONG_HOLD    = 60;
    localparam int PHASE_ITEMS  = 50;
    localparam int RANDOM_PHASES = 8;
    localparam int HOLD_PHASE   = 2;

    // Indexes past the last register; writes to them must be ignored.
    localparam logic [CFG_ADDR_WIDTH-1:0] REG_UNUSED_FIRST = 3'd5;
    localparam int REG_UNUSED_SPAN = 3;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } feed_item_t;

    typedef struct packed {
        logic                  found;
        logic [LOC_WIDTH-1:0]  location;
    } scan_result_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_ADDR_WIDTH-1:0] cfg_addr = '0;
    logic [CFG_DATA_WIDTH-1:0] cfg_wdata = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [7:0] s_data_byte = 8'h00;
    logic s_last_byte = 1'b0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic m_found;
    logic signed [LOC_WIDTH-1:0] m_location;

    masked_byte_pattern_scanner_top uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data_byte (s_data_byte),
        .s_last_byte (s_last_byte),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_found     (m_found),
        .m_location  (m_location)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Shadow copy of the registers and the scan state.
    logic [63:0] pat_lo;
    logic [63:0] pat_hi;
    logic [15:0] care;
    logic [4:0]  plen;
    logic [31:0] offs;
    logic [7:0]  win [WIN_DEPTH];
    int unsigned fill;
    logic [31:0] idx;
    bit          done;

    feed_item_t   byte_feed [$];
    scan_result_t expected_hits [$];
    feed_item_t   next_item;
    scan_result_t want;
    int  mismatches = 0;
    int  cycle_count = 0;
    int  src_gap = 0;
    int  sink_stall = 0;
    bit  calm = 1'b0;
    bit  sink_hold_req = 1'b0;

    function automatic int active_len();
        if (plen == 5'd0) return 1;
        if (plen > 5'(WIN_DEPTH)) return WIN_DEPTH;
        return int'(plen);
    endfunction

    function automatic void scan_byte(input logic [7:0] b, input logic last);
        int len;
        bit hit;
        logic [31:0] start;
        logic [LOC_WIDTH-1:0] loc;
        logic [127:0] pat;
        len = active_len();
        for (int i = WIN_DEPTH - 1; i > 0; i--) win[i] = win[i-1];
        win[0] = b;
        if (fill < WIN_DEPTH) fill++;
        pat = {pat_hi, pat_lo};
        hit = !done && (fill >= len);
        // The oldest byte of the window lines up with pattern byte 0.
        for (int i = 0; i < len; i++)
            if (care[i] && win[len-1-i] !== pat[8*i +: 8]) hit = 1'b0;
        if (hit) begin
            start = idx + 32'd1 - 32'(len);
            loc = {2'b00, start} + {{2{offs[31]}}, offs};
            expected_hits.insert(expected_hits.size(), scan_result_t'{1'b1, loc});
            done = 1'b1;
        end else if (last && !done) begin
            expected_hits.insert(expected_hits.size(), scan_result_t'{1'b0, '0});
        end
        idx = idx + 32'd1;
        if (last) begin
            fill = 0;
            idx = '0;
            done = 1'b0;
        end
    endfunction

    task automatic write_reg(input logic [CFG_ADDR_WIDTH-1:0] addr,
                             input logic [CFG_DATA_WIDTH-1:0] data);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_addr <= addr;
        cfg_wdata <= data;
        case (addr)
            REG_PATTERN_LOW:  pat_lo = data;
            REG_PATTERN_HIGH: pat_hi = data;
            REG_CARE_MASK:    care = data[15:0];
            REG_PATTERN_LEN:  plen = data[4:0];
            REG_RESULT_OFF:   offs = data[31:0];
            default: ;
        endcase
    endtask

    task automatic load_config(input logic [63:0] lo, input logic [63:0] hi,
                               input logic [15:0] cm, input logic [4:0] len,
                               input logic [31:0] off);
        // Upper bits beyond each register's width carry noise on purpose.
        write_reg(REG_PATTERN_LOW, lo);
        write_reg(REG_PATTERN_HIGH, hi);
        write_reg(REG_CARE_MASK, {$urandom, 16'($urandom), cm});
        write_reg(REG_PATTERN_LEN, {$urandom, 27'($urandom), len});
        write_reg(REG_RESULT_OFF, {$urandom, off});
        write_reg(REG_UNUSED_FIRST + 3'($urandom_range(0, REG_UNUSED_SPAN - 1)),
                  {$urandom, $urandom});
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic push_byte(input logic [7:0] data, input logic last);
        byte_feed.insert(byte_feed.size(), feed_item_t'{data, last});
    endtask

    // One scan of n bytes, optionally with the pattern planted somewhere in it.
    task automatic queue_scan(input int n, input bit plant);
        logic [7:0] bytes [$];
        int len;
        int pos;
        int flip;
        logic [127:0] pat;
        len = active_len();
        pat = {pat_hi, pat_lo};
        for (int i = 0; i < n; i++) bytes.insert(bytes.size(), 8'($urandom));
        if (plant && n >= len) begin
            pos = $urandom_range(0, n - len);
            for (int i = 0; i < len; i++)
                if (care[i]) bytes[pos+i] = pat[8*i +: 8];
            // Sometimes spoil one byte to make a near miss.
            if ($urandom_range(0, 3) == 0) begin
                flip = $urandom_range(0, len - 1);
                bytes[pos+flip] ^= 8'(1 << $urandom_range(0, 7));
            end
        end
        for (int i = 0; i < n; i++) push_byte(bytes[i], i == n - 1);
    endtask

    task automatic wait_idle();
        do @(negedge aclk);
        while (byte_feed.size() != 0 || s_valid || expected_hits.size() != 0);
        // A trailing scan byte may still be in flight with no result due.
        repeat (SETTLE) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic random_config(input bit sparse);
        logic [4:0] len;
        logic [15:0] cm;
        logic [31:0] off;
        case ($urandom_range(0, 5))
            0: len = 5'd0;
            1: len = 5'd1;
            2: len = 5'd16;
            3: len = 5'($urandom_range(17, 31));
            default: len = 5'($urandom_range(2, 8));
        endcase
        case ($urandom_range(0, 3))
            0: cm = 16'h0000;
            1: cm = 16'hFFFF;
            default: cm = 16'($urandom);
        endcase
        case ($urandom_range(0, 4))
            0: off = 32'h7FFF_FFFF;
            1: off = 32'h8000_0000;
            2: off = 32'($urandom_range(0, 15)) - 32'd8;
            default: off = $urandom;
        endcase
        if (sparse) begin
            len = 5'd1;
            cm = 16'h0000;
        end
        load_config({$urandom, $urandom}, {$urandom, $urandom}, cm, len, off);
    endtask

    // Sender: one payload change per edge, held until accepted.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            src_gap <= 0;
        end else begin
            if (s_valid && s_ready) scan_byte(s_data_byte, s_last_byte);
            if (!s_valid || s_ready) begin
                if (src_gap != 0) begin
                    s_valid <= 1'b0;
                    src_gap <= src_gap - 1;
                end else if (byte_feed.size() != 0) begin
                    next_item = byte_feed.pop_front();
                    s_valid <= 1'b1;
                    s_data_byte <= next_item.data;
                    s_last_byte <= next_item.last;
                    if (!calm && $urandom_range(0, 5) == 0) src_gap <= $urandom_range(1, 3);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: random short stalls plus one long hold on request.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            sink_stall <= 0;
        end else if (sink_hold_req) begin
            m_ready <= 1'b0;
            sink_stall <= LONG_HOLD;
        end else if (sink_stall != 0) begin
            m_ready <= 1'b0;
            sink_stall <= sink_stall - 1;
        end else if (!calm && $urandom_range(0, 5) == 0) begin
            m_ready <= 1'b0;
            sink_stall <= $urandom_range(0, 2);
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_hits.size() == 0) begin
                $error("unexpected result: found %0d location %0d", m_found, m_location);
                mismatches++;
            end else begin
                want = expected_hits.pop_front();
                if (m_found !== want.found) begin
                    $error("found: expected %0d, got %0d", want.found, m_found);
                    mismatches++;
                end
                if (m_location !== want.location) begin
                    $error("location: expected %0d, got %0d",
                           $signed(want.location), m_location);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        int count;
        int n;
        logic [127:0] alt;
        pat_lo = '0;
        pat_hi = '0;
        care = '0;
        plen = 5'd1;
        offs = '0;
        for (int i = 0; i < WIN_DEPTH; i++) win[i] = 8'h00;
        fill = 0;
        idx = '0;
        done = 1'b0;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Reset values: length one, all wildcards, so the first byte matches.
        push_byte(8'hFF, 1'b0);
        push_byte(8'h00, 1'b1);
        wait_idle();

        // Length zero acts as one; most negative offset; match on the last
        // byte; a scan with no match; a second match in one scan is ignored.
        load_config(64'h0000_0000_0000_00FF, 64'h0, 16'h0001, 5'd0, 32'h8000_0000);
        push_byte(8'h00, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b1);
        push_byte(8'h00, 1'b1);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b1);
        wait_idle();

        // Oversized length saturates to sixteen; largest offset.
        alt = {8{16'h00FF}};
        load_config(alt[63:0], alt[127:64], 16'hFFFF, 5'd31, 32'h7FFF_FFFF);
        for (int i = 0; i < WIN_DEPTH; i++) push_byte(alt[8*i +: 8], i == WIN_DEPTH - 1);
        wait_idle();

        // All wildcards, but the scan ends before the window is full.
        load_config(64'h0, 64'h0, 16'h0000, 5'd16, 32'h0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h00, 1'b1);
        wait_idle();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            if (p == RANDOM_PHASES - 1) calm = 1'b1;
            random_config(p == HOLD_PHASE);
            count = 0;
            while (count < PHASE_ITEMS) begin
                if (p == HOLD_PHASE) n = $urandom_range(1, 3);
                else n = $urandom_range(1, active_len() + 6);
                queue_scan(n, $urandom_range(0, 3) != 0);
                count += n;
            end
            if (p == HOLD_PHASE) begin
                // Every scan here yields a result, so a long hold backs up the block.
                sink_hold_req = 1'b1;
                @(negedge aclk);
                sink_hold_req = 1'b0;
            end
            wait_idle();
        end

        repeat (8) @(posedge aclk);
        if (mismatches == 0 && expected_hits.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
